/* hdl/ecmp_flow_hash_path_select_macros.svh */
// assertion macros shared by the flow hash path select blocks
`ifndef ECMP_FLOW_HASH_PATH_SELECT_MACROS_SVH
`define ECMP_FLOW_HASH_PATH_SELECT_MACROS_SVH

// same-cycle implication, checked outside reset
`define EFHPS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define EFHPS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/efhps_pkg.sv */
// types, constants and hash helpers for the ecmp flow hash path select block
`default_nettype none
package efhps_pkg;

  localparam int MAX_PATHS = 64;
  localparam int PATHS_W   = $clog2(MAX_PATHS + 1);
  localparam int REM_W     = $clog2(MAX_PATHS);

  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] ADDR_HASH_SEED = 3'd0;

  localparam logic [31:0] MM_C1 = 32'hcc9e2d51;
  localparam logic [31:0] MM_C2 = 32'h1b873593;
  localparam logic [31:0] MM_N  = 32'he6546b64;
  localparam logic [31:0] MM_F1 = 32'h85ebca6b;
  localparam logic [31:0] MM_F2 = 32'hc2b2ae35;
  localparam logic [31:0] KEY_BYTES = 32'd12;

  localparam logic [7:0] PROTO_TCP  = 8'h06;
  localparam logic [7:0] PROTO_UDP  = 8'h11;
  localparam logic [7:0] PROTO_ACK0 = 8'hfc;
  localparam logic [7:0] PROTO_ACK1 = 8'hfd;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [7:0]  protocol;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [6:0]  path_count;
  } in_data_t;

  typedef struct packed {
    logic [31:0] flow_hash;
    logic [5:0]  path_index;
  } out_data_t;

  // classified item as it waits between front and back
  typedef struct packed {
    logic [31:0]        src_addr;
    logic [31:0]        dst_addr;
    logic [31:0]        port_word;
    logic [PATHS_W-1:0] paths;
  } flow_key_t;

  typedef struct packed {
    logic push;
    logic full;
  } q_wr_t;

  function automatic logic [31:0] rotl15(input logic [31:0] x);
    return {x[16:0], x[31:17]};
  endfunction

  // one murmur round on the running state, k already scrambled
  function automatic logic [31:0] mix_h(input logic [31:0] h, input logic [31:0] k);
    logic [31:0] t;
    t = h ^ k;
    t = {t[18:0], t[31:19]};
    return (t << 2) + t + MM_N;
  endfunction

  // eight restoring remainder steps, msb first
  function automatic logic [REM_W-1:0] mod_step8(input logic [REM_W-1:0] rem,
                                                 input logic [7:0] bits,
                                                 input logic [PATHS_W-1:0] paths);
    logic [PATHS_W-1:0] t;
    logic [REM_W-1:0]   r;
    r = rem;
    for (int i = 7; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= paths) t = t - paths;
      r = t[REM_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/efhps_front.sv */
// front stage: takes packet headers, builds the port word and the effective path count
`default_nettype none
module efhps_front
  import efhps_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_data_t  in_data,
  output q_wr_t          q_wr,
  input  wire logic      q_full,
  output flow_key_t      q_data
);

  logic      fv_r;
  flow_key_t key_r;
  flow_key_t key_nxt;
  logic      uses_ports;

  always_comb begin
    uses_ports = (in_data.protocol == PROTO_TCP) || (in_data.protocol == PROTO_UDP) ||
                 (in_data.protocol == PROTO_ACK0) || (in_data.protocol == PROTO_ACK1);
    key_nxt.src_addr  = in_data.src_addr;
    key_nxt.dst_addr  = in_data.dst_addr;
    key_nxt.port_word = uses_ports ? {in_data.dst_port, in_data.src_port} : 32'd0;
    // zero paths means one, anything above the limit saturates
    if (in_data.path_count == '0) begin
      key_nxt.paths = PATHS_W'(1);
    end else if (PATHS_W'(in_data.path_count) > PATHS_W'(MAX_PATHS)) begin
      key_nxt.paths = PATHS_W'(MAX_PATHS);
    end else begin
      key_nxt.paths = PATHS_W'(in_data.path_count);
    end
  end

  assign in_stall  = fv_r && q_full;
  assign q_wr.push = fv_r && !q_full;
  assign q_wr.full = q_full;
  assign q_data    = key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (!in_stall) begin
      fv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      key_r <= key_nxt;
    end
  end

endmodule
`default_nettype wire

/* hdl/efhps_fifo.sv */
// short queue of classified flow keys between front and back
`default_nettype none
`include "ecmp_flow_hash_path_select_macros.svh"
module efhps_fifo
  import efhps_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire q_wr_t     q_wr,
  input  wire flow_key_t wr_data,
  output logic           full,
  output logic           rd_valid,
  input  wire logic      pop,
  output flow_key_t      rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  flow_key_t          mem_r [DEPTH];
  logic [PTR_W-1:0]   wp_r, rp_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign do_push  = q_wr.push && !q_wr.full;
  assign do_pop   = pop && rd_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  `EFHPS_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CNT_W'(DEPTH), "queue count over depth")
  `EFHPS_ASSERT_NXT(a_cnt_inc, clk, rst_n, do_push && !do_pop, cnt_r == CNT_W'($past(cnt_r) + 1'b1), "queue count missed a push")

endmodule
`default_nettype wire

/* hdl/efhps_back.sv */
// back stage: murmur3 hash pipeline followed by a pipelined remainder by path count
`default_nettype none
`include "ecmp_flow_hash_path_select_macros.svh"
module efhps_back
  import efhps_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic [31:0] hash_seed,
  input  wire logic      q_valid,
  input  wire flow_key_t q_data,
  output logic           pop,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_data_t      out_data
);

  localparam int NSTG = 12;

  logic [NSTG:1]      v_r;
  logic               en;

  // key scramble
  logic [31:0]        ka_r [3];
  logic [31:0]        kb_r [3];
  logic [31:0]        h1_r, k1seed_r;
  // state chain and finalization
  logic [31:0]        h3_r, h4_r, h5_r, h6_r, h7_r, h8_r;
  logic [31:0]        k1_3_r, k2_3_r, k2_4_r;
  logic [31:0]        h5_nxt;
  // remainder
  logic [31:0]        hq_r [9:12];
  logic [REM_W-1:0]   rem_r [9:12];
  logic [PATHS_W-1:0] p_r [1:12];

  assign en        = !(v_r[NSTG] && out_stall);
  assign pop       = en && q_valid;
  assign out_valid = v_r[NSTG];
  assign out_data.flow_hash  = hq_r[12];
  assign out_data.path_index = 6'(rem_r[12]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NSTG-1:1], q_valid};
    end
  end

  always_comb begin
    h5_nxt = mix_h(h4_r, k2_4_r) ^ KEY_BYTES;
    h5_nxt = h5_nxt ^ (h5_nxt >> 16);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ka_r[0]  <= q_data.src_addr * MM_C1;
      ka_r[1]  <= q_data.dst_addr * MM_C1;
      ka_r[2]  <= q_data.port_word * MM_C1;
      k1seed_r <= hash_seed;
      p_r[1]   <= q_data.paths;

      kb_r[0] <= rotl15(ka_r[0]) * MM_C2;
      kb_r[1] <= rotl15(ka_r[1]) * MM_C2;
      kb_r[2] <= rotl15(ka_r[2]) * MM_C2;
      h1_r    <= k1seed_r;

      h3_r   <= mix_h(h1_r, kb_r[0]);
      k1_3_r <= kb_r[1];
      k2_3_r <= kb_r[2];
      h4_r   <= mix_h(h3_r, k1_3_r);
      k2_4_r <= k2_3_r;
      h5_r   <= h5_nxt;
      h6_r   <= h5_r * MM_F1;
      h7_r   <= (h6_r ^ (h6_r >> 13)) * MM_F2;
      h8_r   <= h7_r ^ (h7_r >> 16);

      hq_r[9]  <= h8_r;
      rem_r[9] <= mod_step8('0, h8_r[31:24], p_r[8]);
      for (int s = 10; s <= 12; s++) begin
        hq_r[s]  <= hq_r[s-1];
        rem_r[s] <= mod_step8(rem_r[s-1], hq_r[s-1][(12-s)*8 +: 8], p_r[s-1]);
      end
      for (int s = 2; s <= 12; s++) begin
        p_r[s] <= p_r[s-1];
      end
    end
  end

  `EFHPS_ASSERT_IMP(a_idx_range, clk, rst_n, v_r[NSTG], PATHS_W'(rem_r[12]) < p_r[12], "path index not below path count")
  `EFHPS_ASSERT_NXT(a_hold, clk, rst_n, !en, $stable(v_r), "pipeline moved while held")

endmodule
`default_nettype wire

/* hdl/ecmp_flow_hash_path_select.sv */
// top level: config register, front classifier, key queue and hash back end
// One packet header is accepted per cycle while in_stall is low, and one result per header
// leaves in order. A header passes through the front register, the key queue and the back
// pipeline (the MurmurHash3 rounds and finalization, each multiply behind a register, then
// the final mix, then the remainder by path count at eight bits a stage). While a result
// waits at the output under out_stall the back pipeline holds; the queue of QUEUE_DEPTH
// entries then fills and in_stall rises once it and the front register are full. A path
// count of zero acts as one path and one above 64 as 64. hash_seed sits at byte address 0;
// the user must write it only while no header is in flight, as the block does not enforce it.
`default_nettype none
module ecmp_flow_hash_path_select
  import efhps_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_data_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_data_t                  out_data,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]           cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);

  logic [31:0] seed_r;
  q_wr_t       q_wr;
  logic        q_full, q_valid, q_pop;
  flow_key_t   q_wdata, q_rdata;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_HASH_SEED) ? seed_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= 32'd0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == ADDR_HASH_SEED) begin
      seed_r <= cfg_pwdata;
    end
  end

  efhps_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_wr     (q_wr),
    .q_full   (q_full),
    .q_data   (q_wdata)
  );

  efhps_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_wr     (q_wr),
    .wr_data  (q_wdata),
    .full     (q_full),
    .rd_valid (q_valid),
    .pop      (q_pop),
    .rd_data  (q_rdata)
  );

  efhps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .hash_seed (seed_r),
    .q_valid   (q_valid),
    .q_data    (q_rdata),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
